// File: rtl/mm3_pkg.sv
// Shared types, constants and helper functions for the murmur3 x86 128-bit hash block.
// No dependencies; every rtl file imports this package.
package mm3_pkg;

	// Stream widths: payload fields packed from bit 0, padded to whole bytes
	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 128;
	localparam int CFG_IDX_W = 2;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 2'd1;

	localparam logic [4:0] BLOCK_BYTES = 5'd16;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] lanes_t;

	// Key mix constants per lane: k * KEY_CA, rotate, * KEY_CB
	localparam lanes_t KEY_CA = {32'ha1e38b93, 32'h38b34ae5, 32'hab0e9789, 32'h239b961b};
	localparam lanes_t KEY_CB = {32'h239b961b, 32'ha1e38b93, 32'h38b34ae5, 32'hab0e9789};
	localparam logic [3:0][4:0] KEY_ROT = {5'd18, 5'd17, 5'd16, 5'd15};

	// Lane update constants of the body mix
	localparam logic [3:0][4:0] LANE_ROT = {5'd13, 5'd15, 5'd17, 5'd19};
	localparam lanes_t LANE_ADD = {32'h32ac3b17, 32'h96cd1c35, 32'h0bcaa747, 32'h561ccd1b};

	// Final avalanche multipliers
	localparam word_t FMIX_M1 = 32'h85ebca6b;
	localparam word_t FMIX_M2 = 32'hc2b2ae35;

	// One queued block: mixed key words and what to do with them
	typedef struct packed {
		lanes_t     km;
		logic       body;
		logic       last;
		logic [4:0] add;
	} mm3_entry_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} mm3_qstat_t;

	// Back-end status
	typedef struct packed {
		logic busy;
		logic idle;
	} mm3_bstat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX_B,
		ST_FIN_A,
		ST_FIN_B,
		ST_FMIX1,
		ST_FMIX2,
		ST_FMIX3,
		ST_OUT
	} mm3_state_t;

	function automatic word_t rotl32(input word_t v, input logic [4:0] r);
		return (v << r) | (v >> (6'd32 - {1'b0, r}));
	endfunction

	// v * 5 + c as shift-add
	function automatic word_t mul5_add(input word_t v, input word_t c);
		return (v << 2) + v + c;
	endfunction

endpackage

// File: rtl/mm3_front.sv
// Front end: takes input beats, masks tail bytes and runs the two-multiply key mix.
// Depends on mm3_pkg; feeds mm3_fifo.
module mm3_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// data_low [63:0], data_high [127:64], valid_bytes [132:128], zero pad
	input  logic [mm3_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	input  mm3_pkg::mm3_qstat_t           qstat,
	output logic                          push,
	output mm3_pkg::mm3_entry_t           push_entry
);
	import mm3_pkg::*;

	logic       v_s1, v_s2;
	logic       ready_s1, ready_s2;
	lanes_t     prod_s1, prod_s2;
	logic       body_s1, body_s2;
	logic       last_s1, last_s2;
	logic [4:0] add_s1, add_s2;

	logic [4:0]   vb_sat;
	logic [4:0]   nbytes;
	logic [127:0] masked;
	lanes_t       prod_d;
	lanes_t       prod2_d;

	// Stage handshake
	assign ready_s2 = !v_s2 || !qstat.full;
	assign ready_s1 = !v_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign push     = v_s2 && !qstat.full;

	// Byte count, tail masking and the first key multiply
	always_comb begin
		vb_sat = (s_tdata[132:128] > BLOCK_BYTES) ? BLOCK_BYTES : s_tdata[132:128];
		nbytes = s_tlast ? vb_sat : BLOCK_BYTES;
		for (int b = 0; b < 16; b++) begin
			masked[8*b +: 8] = (5'(b) < nbytes) ? s_tdata[8*b +: 8] : 8'h00;
		end
		for (int i = 0; i < 4; i++) begin
			prod_d[i] = word_t'(masked[32*i +: 32] * KEY_CA[i]);
		end
	end

	// Second multiply after the rotate
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod2_d[i] = word_t'(rotl32(prod_s1[i], KEY_ROT[i]) * KEY_CB[i]);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= s_tvalid;
			if (ready_s2) v_s2 <= v_s1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			prod_s1 <= prod_d;
			body_s1 <= (nbytes == BLOCK_BYTES);
			last_s1 <= s_tlast;
			add_s1  <= nbytes;
		end
		if (ready_s2 && v_s1) begin
			prod_s2 <= prod2_d;
			body_s2 <= body_s1;
			last_s2 <= last_s1;
			add_s2  <= add_s1;
		end
	end

	assign push_entry = '{km: prod_s2, body: body_s2, last: last_s2, add: add_s2};

endmodule

// File: rtl/mm3_fifo.sv
// Short queue of mixed blocks between the front end and the lane unit.
// Depends on mm3_pkg.
module mm3_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mm3_pkg::mm3_entry_t push_entry,
	input  logic                pop,
	output mm3_pkg::mm3_entry_t head,
	output mm3_pkg::mm3_qstat_t qstat
);
	import mm3_pkg::*;

	mm3_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// File: rtl/mm3_back.sv
// Back end: hash lanes, byte total, seed registers, finalization and the result register.
// Depends on mm3_pkg; reads mm3_fifo.
module mm3_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mm3_pkg::mm3_entry_t           head,
	input  mm3_pkg::mm3_qstat_t           qstat,
	output logic                          pop,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mm3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hash_low [63:0], hash_high [127:64]
	output logic [mm3_pkg::M_TDATA_W-1:0] m_tdata,
	output mm3_pkg::mm3_bstat_t           bstat
);
	import mm3_pkg::*;

	mm3_state_t state_q, state_d;
	lanes_t     lanes_q, lanes_d;
	word_t      total_q, total_d;
	word_t      km3_q, km3_d;
	logic       last_q, last_d;
	logic       busy_q, busy_d;
	logic [63:0] seed_low_q, seed_low_d, seed_high_q, seed_high_d;
	logic       out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q, out_data_d;
	logic       load_out;

	assign cfg_ready  = 1'b1;
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign bstat.busy = busy_q;
	assign bstat.idle = (state_q == ST_IDLE);

	// Next state and lane datapath
	always_comb begin
		lanes_t x;
		state_d     = state_q;
		lanes_d     = lanes_q;
		total_d     = total_q;
		km3_d       = km3_q;
		last_d      = last_q;
		busy_d      = busy_q;
		seed_low_d  = seed_low_q;
		seed_high_d = seed_high_q;
		pop         = 1'b0;
		load_out    = 1'b0;
		x           = lanes_q;
		out_data_d  = {lanes_q[3] + lanes_q[0], lanes_q[2] + lanes_q[0],
		               lanes_q[1] + lanes_q[0], lanes_q[0]};

		unique case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					busy_d  = 1'b1;
					total_d = total_q + 32'(head.add);
					km3_d   = head.km[3];
					last_d  = head.last;
					if (head.body) begin
						// lanes one to three; lane four needs the new lane one
						for (int i = 0; i < 3; i++) begin
							lanes_d[i] = mul5_add(rotl32(lanes_q[i] ^ head.km[i], LANE_ROT[i])
							                      + lanes_q[i+1], LANE_ADD[i]);
						end
						state_d = ST_MIX_B;
					end else begin
						// tail: uncovered lanes carry a zero key
						for (int i = 0; i < 4; i++) lanes_d[i] = lanes_q[i] ^ head.km[i];
						state_d = head.last ? ST_FIN_A : ST_IDLE;
					end
				end
			end
			ST_MIX_B: begin
				lanes_d[3] = mul5_add(rotl32(lanes_q[3] ^ km3_q, LANE_ROT[3]) + lanes_q[0],
				                      LANE_ADD[3]);
				state_d = last_q ? ST_FIN_A : ST_IDLE;
			end
			ST_FIN_A: begin
				for (int i = 0; i < 4; i++) x[i] = lanes_q[i] ^ total_q;
				lanes_d    = x;
				lanes_d[0] = x[0] + x[1] + x[2] + x[3];
				state_d    = ST_FIN_B;
			end
			ST_FIN_B: begin
				for (int i = 1; i < 4; i++) lanes_d[i] = lanes_q[i] + lanes_q[0];
				state_d = ST_FMIX1;
			end
			ST_FMIX1: begin
				for (int i = 0; i < 4; i++) begin
					lanes_d[i] = word_t'((lanes_q[i] ^ (lanes_q[i] >> 16)) * FMIX_M1);
				end
				state_d = ST_FMIX2;
			end
			ST_FMIX2: begin
				for (int i = 0; i < 4; i++) begin
					lanes_d[i] = word_t'((lanes_q[i] ^ (lanes_q[i] >> 13)) * FMIX_M2);
				end
				state_d = ST_FMIX3;
			end
			ST_FMIX3: begin
				for (int i = 0; i < 4; i++) x[i] = lanes_q[i] ^ (lanes_q[i] >> 16);
				lanes_d    = x;
				lanes_d[0] = x[0] + x[1] + x[2] + x[3];
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				// final lane sums go straight to the result register
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					lanes_d  = {seed_high_q[63:32], seed_high_q[31:0],
					            seed_low_q[63:32], seed_low_q[31:0]};
					total_d  = '0;
					busy_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// Seed writes; lanes reload only between messages
		if (cfg_valid) begin
			unique case (cfg_index)
				REG_SEED_LOW: begin
					seed_low_d = cfg_data;
					if (!busy_q) begin
						lanes_d[0] = cfg_data[31:0];
						lanes_d[1] = cfg_data[63:32];
					end
				end
				REG_SEED_HIGH: begin
					seed_high_d = cfg_data;
					if (!busy_q) begin
						lanes_d[2] = cfg_data[31:0];
						lanes_d[3] = cfg_data[63:32];
					end
				end
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lanes, totals, seeds, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q     <= '0;
			total_q     <= '0;
			busy_q      <= 1'b0;
			last_q      <= 1'b0;
			seed_low_q  <= '0;
			seed_high_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			lanes_q     <= lanes_d;
			total_q     <= total_d;
			busy_q      <= busy_d;
			last_q      <= last_d;
			seed_low_q  <= seed_low_d;
			seed_high_q <= seed_high_d;
			if (load_out)      out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		km3_q <= km3_d;
		if (load_out) out_data_q <= out_data_d;
	end

endmodule

// File: rtl/murmur3_x86_128_hash.sv
// MurmurHash3 x86 128-bit over a stream of 16-byte blocks. The front end takes one beat
// per cycle while the queue has room and runs the key-word multiplies in two pipeline
// stages; a four-entry queue feeds the lane unit, which updates the four hash lanes with
// shifts and adds. In the lane unit a full block passes ST_IDLE and then ST_MIX_B (lane
// four waits on the new lane one) and a partial last block ST_IDLE alone, so no new block
// is taken while ST_MIX_B runs. The last block then runs the finalization states ST_FIN_A,
// ST_FIN_B, ST_FMIX1, ST_FMIX2, ST_FMIX3 and ST_OUT before the result register is loaded,
// and may first wait behind earlier blocks. The next message can enter while a result
// waits on m_tready. Seed writes go through cfg at any time the block is idle; the lanes
// reload from the seed after every result. No clearing pass.
// Depends on mm3_pkg, mm3_front, mm3_fifo and mm3_back.
module murmur3_x86_128_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// data_low [63:0], data_high [127:64], valid_bytes [132:128], zero pad
	input  logic [mm3_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hash_low [63:0], hash_high [127:64]
	output logic [mm3_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mm3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import mm3_pkg::*;

	mm3_qstat_t qstat;
	mm3_bstat_t bstat;
	mm3_entry_t push_entry, head;
	logic       push, pop;

	mm3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	mm3_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	mm3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.bstat     (bstat)
	);

	// Queue can never read as both full and empty
	a_qstat: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue full and empty at once");

	// Input stalls only when the queue backs up the front pipeline
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> qstat.full)
		else $error("input stalled with room in queue");

	// Lane unit works only inside a message
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!bstat.idle |-> bstat.busy)
		else $error("lane unit active outside a message");

	// A new result always ends the message
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !bstat.busy && bstat.idle)
		else $error("result raised while message still open");

endmodule

// File: bench/tb_murmur3_x86_128_hash.sv
// Self-checking bench for the murmur3 x86 128-bit stream hash: directed and random messages,
// seed register writes between phases, and a stalled receiver that backs up the input stream.
// Depends on mm3_pkg and the murmur3_x86_128_hash RTL.
`timescale 1ns / 1ps

module tb_murmur3_x86_128_hash;
	import mm3_pkg::*;

	typedef logic [31:0] u32;
	typedef logic [3:0][31:0] lanes4_t;

	// Register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

	// Key scrambling constants per lane
	localparam lanes4_t KEY_MUL_A = {32'ha1e38b93, 32'h38b34ae5, 32'hab0e9789, 32'h239b961b};
	localparam lanes4_t KEY_MUL_B = {32'h239b961b, 32'ha1e38b93, 32'h38b34ae5, 32'hab0e9789};
	localparam logic [3:0][4:0] KEY_ROL = {5'd18, 5'd17, 5'd16, 5'd15};
	// Lane update constants
	localparam logic [3:0][4:0] LANE_ROL = {5'd13, 5'd15, 5'd17, 5'd19};
	localparam lanes4_t LANE_OFS = {32'h32ac3b17, 32'h96cd1c35, 32'h0bcaa747, 32'h561ccd1b};
	localparam u32 AVAL_M1 = 32'h85ebca6b;
	localparam u32 AVAL_M2 = 32'hc2b2ae35;

	localparam int ITEM_TARGET   = 1050;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT   = 5000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// data_low [63:0], data_high [127:64], valid_bytes [132:128], zero pad
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// hash_low [63:0], hash_high [127:64]
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;

	// Shadow hash state
	logic [63:0]  seed_lo, seed_hi;
	lanes4_t      lane;
	u32           msg_bytes;
	logic         msg_open;
	logic [127:0] digest_q[$];

	int  mismatches  = 0;
	int  items_sent  = 0;
	int  idle_cycles = 0;
	int  hold_req    = 0;
	int  hold_ack    = 0;
	int  hold_left   = 0;
	bit  src_gaps    = 1'b1;
	bit  sink_gaps   = 1'b1;

	murmur3_x86_128_hash DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- hash prediction

	function automatic u32 rol32(input u32 v, input logic [4:0] r);
		return (v << r) | (v >> (32 - r));
	endfunction

	function automatic u32 scramble_key(input u32 k, input int i);
		u32 t;
		t = k * KEY_MUL_A[i];
		t = rol32(t, KEY_ROL[i]);
		return t * KEY_MUL_B[i];
	endfunction

	function automatic u32 avalanche(input u32 h);
		u32 t;
		t = h ^ (h >> 16);
		t = t * AVAL_M1;
		t = t ^ (t >> 13);
		t = t * AVAL_M2;
		return t ^ (t >> 16);
	endfunction

	function automatic void reload_lanes();
		lane = {seed_hi, seed_lo};
	endfunction

	// Lane sums used twice in finalization
	function automatic void fold_lanes();
		lane[0] = lane[0] + lane[1] + lane[2] + lane[3];
		for (int i = 1; i < 4; i++)
			lane[i] = lane[i] + lane[0];
	endfunction

	// Full-block lane update; lane four sees the new lane one
	function automatic void mix_full_block(input lanes4_t k);
		for (int i = 0; i < 4; i++) begin
			lane[i] = lane[i] ^ scramble_key(k[i], i);
			lane[i] = rol32(lane[i], LANE_ROL[i]) + lane[(i + 1) % 4];
			lane[i] = lane[i] * 5 + LANE_OFS[i];
		end
	endfunction

	// Update the shadow state with one accepted beat; a last beat queues a digest
	function automatic void absorb_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] vb, input logic last);
		lanes4_t     k;
		u32          w;
		int unsigned nb;
		int unsigned n;
		k = {hi, lo};
		if (!last) begin
			mix_full_block(k);
			msg_bytes = msg_bytes + 32'd16;
			msg_open = 1'b1;
			return;
		end
		nb = (vb > 5'd16) ? 16 : vb;
		if (nb == 16) begin
			mix_full_block(k);
		end else begin
			// partial tail: only words that hold a valid byte, high bytes masked off
			for (int i = 0; i < 4; i++) begin
				if (nb > 4 * i) begin
					n = nb - 4 * i;
					w = k[i];
					if (n < 4)
						w = w & ((32'd1 << (8 * n)) - 32'd1);
					lane[i] = lane[i] ^ scramble_key(w, i);
				end
			end
		end
		msg_bytes = msg_bytes + u32'(nb);
		for (int i = 0; i < 4; i++)
			lane[i] = lane[i] ^ msg_bytes;
		fold_lanes();
		for (int i = 0; i < 4; i++)
			lane[i] = avalanche(lane[i]);
		fold_lanes();
		digest_q.push_back(lane);
		reload_lanes();
		msg_bytes = '0;
		msg_open = 1'b0;
	endfunction

	// ---------------------------------------------------------------- receiver and checks

	// Sink readiness: random gaps, or a long hold when one is requested
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready = 1'b0;
		end else if (sink_gaps) begin
			m_tready = ($urandom_range(99) >= 26);
		end else begin
			m_tready = 1'b1;
		end
	end

	// Result beats against the oldest queued digest
	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected result beat: %h", m_tdata);
				mismatches++;
			end else begin
				want = digest_q.pop_front();
				if (m_tdata[63:0] !== want[63:0]) begin
					$error("hash_low: expected %h, got %h", want[63:0], m_tdata[63:0]);
					mismatches++;
				end
				if (m_tdata[127:64] !== want[127:64]) begin
					$error("hash_high: expected %h, got %h", want[127:64], m_tdata[127:64]);
					mismatches++;
				end
			end
		end
	end

	// Stall watchdog: no beat on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("murmur3_x86_128_hash regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- drivers

	function automatic logic [63:0] pick_word64();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return 64'd0;
		if (r < 12)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// One input beat; called and returns at a falling edge
	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] vb, input logic last);
		while (src_gaps && $urandom_range(99) < 26) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {3'b000, vb, hi, lo};
		s_tlast = last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_block(lo, hi, vb, last);
		items_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Message of nfull full beats and a last beat of random length
	task automatic send_message(input int nfull);
		logic [4:0] vb;
		for (int i = 0; i < nfull; i++)
			send_block(pick_word64(), pick_word64(), 5'($urandom_range(31)), 1'b0);
		if ($urandom_range(99) < 8)
			vb = 5'($urandom_range(31, 17));
		else
			vb = 5'($urandom_range(16));
		send_block(pick_word64(), pick_word64(), vb, 1'b1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_SEED_LOW)
			seed_lo = val;
		else if (idx == REG_SEED_HIGH)
			seed_hi = val;
		if (!msg_open && (idx == REG_SEED_LOW || idx == REG_SEED_HIGH))
			reload_lanes();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (digest_q.size() != 0)
			@(negedge clk);
	endtask

	// Drain all results, let the pipeline settle, then load a new seed
	task automatic set_seed(input logic [63:0] lo, input logic [63:0] hi);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_SEED_LOW, lo);
		write_reg(REG_SEED_HIGH, hi);
	endtask

	// ---------------------------------------------------------------- tests

	// Field extremes, every tail length class, saturation and empty message
	task automatic test_directed();
		send_block(64'd0, 64'd0, 5'd0, 1'b1);
		send_block(64'd0, 64'd0, 5'd16, 1'b1);
		send_block('1, '1, 5'd16, 1'b1);
		for (int i = 0; i < 4; i++) begin
			send_block('1, '1, 5'(4 * i + 1), 1'b1);
			send_block('1, '1, 5'(4 * i + 3), 1'b1);
		end
		send_block('1, '1, 5'd4, 1'b1);
		send_block('1, '1, 5'd17, 1'b1);
		send_block('1, '1, 5'd31, 1'b1);
		// non-last beats ignore their length field
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd0, 1'b0);
		send_block('1, 64'd0, 5'd31, 1'b0);
		send_block(64'd0, '1, 5'd7, 1'b1);
	endtask

	// Seed extremes and writes to unused indexes
	task automatic test_seed_registers();
		set_seed('1, '1);
		send_message(0);
		send_message(2);
		set_seed(64'd0, '1);
		write_reg(REG_SPARE2, {$urandom, $urandom});
		write_reg(REG_SPARE3, '1);
		send_message(1);
		send_message(0);
		set_seed('1, 64'd0);
		send_message(3);
	endtask

	// Receiver stalls long enough for the input side to back up
	task automatic test_backpressure();
		set_seed({$urandom, $urandom}, {$urandom, $urandom});
		src_gaps = 1'b0;
		hold_req = hold_req + 1;
		for (int i = 0; i < 24; i++)
			send_message(i % 3 == 0 ? 1 : 0);
		wait_drained();
		src_gaps = 1'b1;
	endtask

	// Random messages in phases, with a new seed per phase
	task automatic test_random_messages();
		int          phase;
		int unsigned r;
		int          nfull;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase % 6)
				0: set_seed('1, '1);
				1: set_seed(64'd0, 64'd0);
				default: set_seed(pick_word64(), pick_word64());
			endcase
			// one phase runs without any idling on either side
			src_gaps = (phase != 3);
			sink_gaps = (phase != 3);
			for (int n = 0; n < 100 && items_sent < ITEM_TARGET; ) begin
				r = $urandom_range(99);
				if (r < 40)
					nfull = 0;
				else if (r < 85)
					nfull = $urandom_range(3, 1);
				else if (r < 97)
					nfull = $urandom_range(8, 4);
				else
					nfull = $urandom_range(24, 9);
				send_message(nfull);
				n = n + nfull + 1;
			end
			phase++;
		end
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SEED_LOW;
		cfg_data = '0;
		seed_lo = '0;
		seed_hi = '0;
		reload_lanes();
		msg_bytes = '0;
		msg_open = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_seed_registers();
		test_backpressure();
		test_random_messages();

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && digest_q.size() == 0)
			$display("murmur3_x86_128_hash regression: pass");
		else
			$display("murmur3_x86_128_hash regression: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/mm3_pkg.sv
rtl/mm3_front.sv
rtl/mm3_fifo.sv
rtl/mm3_back.sv
rtl/murmur3_x86_128_hash.sv
bench/tb_murmur3_x86_128_hash.sv
